// ===== hdl/sspd_pkg.sv =====
// ----------------------------------------------------------------------------
// sspd_pkg
// Shared types, screen layout constants and palette for the screen pixel
// decoder.
// ----------------------------------------------------------------------------
package sspd_pkg;

   // item operation codes
   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_RENDER = 1'b1
   } op_type;

   // default page count
   localparam int DEFAULT_NUM_PAGES = 2;

   // page layout
   localparam int BITMAP_BYTES  = 6144;
   localparam int ATTR_BYTES    = 768;
   localparam int PAGE_BYTES    = BITMAP_BYTES + ATTR_BYTES;
   localparam int ATTR_BASE     = 'h1800;
   localparam int VISIBLE_LINES = 192;

   // field widths of one beat
   localparam int ADDR_W  = 13;
   localparam int DATA_W  = 8;
   localparam int COL_W   = 5;
   localparam int LINE_W  = 8;
   localparam int COLOR_W = 16;
   localparam int BM_OFS_W = 13;
   localparam int AT_OFS_W = 10;

   // attribute byte fields
   localparam int ATTR_BRIGHT_BIT = 6;

   // byte-swapped rgb565 palette, upper half is bright
   function automatic logic [COLOR_W-1:0] palette_color(input logic [3:0] idx);
      logic [COLOR_W-1:0] c;
      unique case (idx)
         4'd0:    c = 16'h0000;
         4'd1:    c = 16'h1B00;
         4'd2:    c = 16'h00B8;
         4'd3:    c = 16'h17B8;
         4'd4:    c = 16'hE005;
         4'd5:    c = 16'hF705;
         4'd6:    c = 16'hE0BD;
         4'd7:    c = 16'h18C6;
         4'd8:    c = 16'h0000;
         4'd9:    c = 16'h1F00;
         4'd10:   c = 16'h00F8;
         4'd11:   c = 16'h1FF8;
         4'd12:   c = 16'hE007;
         4'd13:   c = 16'hFF07;
         4'd14:   c = 16'hE0FF;
         default: c = 16'hFFFF;
      endcase
      return c;
   endfunction

endpackage

// ===== hdl/sspd_ram.sv =====
// ----------------------------------------------------------------------------
// sspd_ram
// Generic single write port, single read port ram with registered read data.
// ----------------------------------------------------------------------------
module sspd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/spectrum_screen_pixel_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// spectrum_screen_pixel_decoder_unit
// Screen memory for several video pages with a cell-line renderer that
// emits eight palette-coloured pixels per render beat.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | operation, page, address, data, column, line
//   rsp     | out       | rsp_valid / rsp_stall  | pixel_x, pixel_y, pixel_color, last_pixel
//   csr     | in        | csr_write_enable       | video_page
//
// A write beat updates the bitmap or attribute ram.
// A render beat reads both rams in its accept cycle; its eight pixels pass
// through the read stage and the emitter register and leave one per cycle
// while rsp is not stalled. The single pixel emitter works on one render at
// a time. Reset clears the page select and the valid flags; screen ram is
// not cleared. A stalled emitter holds the next render in the read stage and
// then stalls req; write beats keep flowing while the read stage is free.
// ----------------------------------------------------------------------------
module spectrum_screen_pixel_decoder_unit #(
   parameter int NUM_PAGES = sspd_pkg::DEFAULT_NUM_PAGES
) (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_write_enable,
   input  logic                         csr_write_data,
   // request channel
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_operation,
   input  logic                         req_write_page,
   input  logic [sspd_pkg::ADDR_W-1:0]  req_write_address,
   input  logic [sspd_pkg::DATA_W-1:0]  req_write_data,
   input  logic [sspd_pkg::COL_W-1:0]   req_cell_column,
   input  logic [sspd_pkg::LINE_W-1:0]  req_screen_line,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_pixel_x,
   output logic [sspd_pkg::LINE_W-1:0]  rsp_pixel_y,
   output logic [sspd_pkg::COLOR_W-1:0] rsp_pixel_color,
   output logic                         rsp_last_pixel
);

   localparam int BmDepth = NUM_PAGES * sspd_pkg::BITMAP_BYTES;
   localparam int AtDepth = NUM_PAGES * sspd_pkg::ATTR_BYTES;
   localparam int BmAddrW = (BmDepth > 1) ? $clog2(BmDepth) : 1;
   localparam int AtAddrW = (AtDepth > 1) ? $clog2(AtDepth) : 1;

   // configuration register
   logic video_page_ff, video_page_in;

   // read stage
   logic                          a_valid_ff, a_valid_in;
   logic [sspd_pkg::COL_W-1:0]    a_col_ff, a_col_in;
   logic [sspd_pkg::LINE_W-1:0]   a_line_ff, a_line_in;
   logic                          a_vis_ff, a_vis_in;

   // pixel emitter stage
   logic                          b_valid_ff, b_valid_in;
   logic [sspd_pkg::COL_W-1:0]    b_col_ff, b_col_in;
   logic [sspd_pkg::LINE_W-1:0]   b_line_ff, b_line_in;
   logic [sspd_pkg::DATA_W-1:0]   b_bits_ff, b_bits_in;
   logic [sspd_pkg::COLOR_W-1:0]  b_ink_ff, b_ink_in;
   logic [sspd_pkg::COLOR_W-1:0]  b_paper_ff, b_paper_in;
   logic [2:0]                    b_cnt_ff, b_cnt_in;

   logic                          req_beat, rsp_beat;
   logic                          is_render, is_write;
   logic                          line_vis, wr_page_ok, rd_page;
   logic                          b_last, b_free, a_move;
   logic [sspd_pkg::BM_OFS_W-1:0] bm_ofs;
   logic [sspd_pkg::AT_OFS_W-1:0] at_ofs, at_wr_ofs;
   logic                          bm_we, at_we, rd_en;
   logic [BmAddrW-1:0]            bm_wr_addr, bm_rd_addr;
   logic [AtAddrW-1:0]            at_wr_addr, at_rd_addr;
   logic [sspd_pkg::DATA_W-1:0]   bm_rd_data, at_rd_data;
   logic [3:0]                    ink_idx, paper_idx;

   // handshake
   assign req_beat  = req_valid && !req_stall;
   assign rsp_beat  = rsp_valid && !rsp_stall;
   assign is_render = (req_operation == sspd_pkg::OP_RENDER);
   assign is_write  = (req_operation == sspd_pkg::OP_WRITE);
   assign b_last    = (b_cnt_ff == 3'd7);
   assign b_free    = !b_valid_ff || (rsp_beat && b_last);
   assign a_move    = a_valid_ff && b_free;
   assign req_stall = a_valid_ff && !b_free;

   // page select, a missing page reads page 0
   assign rd_page    = (int'(video_page_ff) < NUM_PAGES) ? video_page_ff : 1'b0;
   assign wr_page_ok = (int'(req_write_page) < NUM_PAGES);

   // interleaved bitmap offset and attribute offset inside a page
   assign line_vis = (req_screen_line < sspd_pkg::LINE_W'(sspd_pkg::VISIBLE_LINES));
   assign bm_ofs   = {req_screen_line[7:6], req_screen_line[2:0],
                      req_screen_line[5:3], req_cell_column};
   assign at_ofs   = {req_screen_line[7:3], req_cell_column};

   assign rd_en      = req_beat && is_render && line_vis;
   assign bm_rd_addr = BmAddrW'(rd_page) * BmAddrW'(sspd_pkg::BITMAP_BYTES)
                       + BmAddrW'(bm_ofs);
   assign at_rd_addr = AtAddrW'(rd_page) * AtAddrW'(sspd_pkg::ATTR_BYTES)
                       + AtAddrW'(at_ofs);

   // write decode, bitmap below the attribute base, attributes up to page end
   assign bm_we = req_beat && is_write && wr_page_ok
                  && (req_write_address < sspd_pkg::ADDR_W'(sspd_pkg::ATTR_BASE));
   assign at_we = req_beat && is_write && wr_page_ok
                  && (req_write_address >= sspd_pkg::ADDR_W'(sspd_pkg::ATTR_BASE))
                  && (req_write_address < sspd_pkg::ADDR_W'(sspd_pkg::PAGE_BYTES));
   assign at_wr_ofs  = sspd_pkg::AT_OFS_W'(req_write_address
                                           - sspd_pkg::ADDR_W'(sspd_pkg::ATTR_BASE));
   assign bm_wr_addr = BmAddrW'(req_write_page) * BmAddrW'(sspd_pkg::BITMAP_BYTES)
                       + BmAddrW'(req_write_address);
   assign at_wr_addr = AtAddrW'(req_write_page) * AtAddrW'(sspd_pkg::ATTR_BYTES)
                       + AtAddrW'(at_wr_ofs);

   // bitmap ram
   sspd_ram #(
      .WIDTH (sspd_pkg::DATA_W),
      .DEPTH (BmDepth)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_wr_addr),
      .wr_data (req_write_data),
      .rd_en   (rd_en),
      .rd_addr (bm_rd_addr),
      .rd_data (bm_rd_data)
   );

   // attribute ram
   sspd_ram #(
      .WIDTH (sspd_pkg::DATA_W),
      .DEPTH (AtDepth)
   ) u_attr_ram (
      .clock   (clock),
      .wr_en   (at_we),
      .wr_addr (at_wr_addr),
      .wr_data (req_write_data),
      .rd_en   (rd_en),
      .rd_addr (at_rd_addr),
      .rd_data (at_rd_data)
   );

   // configuration write
   always_comb begin
      video_page_in = csr_write_enable ? csr_write_data : video_page_ff;
   end

   // read stage next state
   always_comb begin
      a_valid_in = a_valid_ff;
      a_col_in   = a_col_ff;
      a_line_in  = a_line_ff;
      a_vis_in   = a_vis_ff;
      if (req_beat && is_render) begin
         a_valid_in = 1'b1;
         a_col_in   = req_cell_column;
         a_line_in  = req_screen_line;
         a_vis_in   = line_vis;
      end else if (a_move) begin
         a_valid_in = 1'b0;
      end
   end

   // attribute decode, flash bit ignored
   assign ink_idx   = {at_rd_data[sspd_pkg::ATTR_BRIGHT_BIT], at_rd_data[2:0]};
   assign paper_idx = {at_rd_data[sspd_pkg::ATTR_BRIGHT_BIT], at_rd_data[5:3]};

   // emitter next state
   always_comb begin
      b_valid_in = b_valid_ff;
      b_col_in   = b_col_ff;
      b_line_in  = b_line_ff;
      b_bits_in  = b_bits_ff;
      b_ink_in   = b_ink_ff;
      b_paper_in = b_paper_ff;
      b_cnt_in   = b_cnt_ff;
      if (a_move) begin
         b_valid_in = 1'b1;
         b_col_in   = a_col_ff;
         b_line_in  = a_line_ff;
         b_cnt_in   = 3'd0;
         if (a_vis_ff) begin
            b_bits_in  = bm_rd_data;
            b_ink_in   = sspd_pkg::palette_color(ink_idx);
            b_paper_in = sspd_pkg::palette_color(paper_idx);
         end else begin
            b_bits_in  = '0;
            b_ink_in   = sspd_pkg::palette_color(4'd0);
            b_paper_in = sspd_pkg::palette_color(4'd0);
         end
      end else if (rsp_beat) begin
         if (b_last) begin
            b_valid_in = 1'b0;
         end else begin
            b_cnt_in = b_cnt_ff + 3'd1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         video_page_ff <= 1'b0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
      end else begin
         video_page_ff <= video_page_in;
         a_valid_ff    <= a_valid_in;
         b_valid_ff    <= b_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      a_col_ff   <= a_col_in;
      a_line_ff  <= a_line_in;
      a_vis_ff   <= a_vis_in;
      b_col_ff   <= b_col_in;
      b_line_ff  <= b_line_in;
      b_bits_ff  <= b_bits_in;
      b_ink_ff   <= b_ink_in;
      b_paper_ff <= b_paper_in;
      b_cnt_ff   <= b_cnt_in;
   end

   // pixel output, msb first
   assign rsp_valid       = b_valid_ff;
   assign rsp_pixel_x     = {b_col_ff, b_cnt_ff};
   assign rsp_pixel_y     = b_line_ff;
   assign rsp_pixel_color = b_bits_ff[3'd7 - b_cnt_ff] ? b_ink_ff : b_paper_ff;
   assign rsp_last_pixel  = b_last;

endmodule

// ===== verif/tb_spectrum_screen_pixel_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// tb_spectrum_screen_pixel_decoder_unit
// Self-checking bench for the screen pixel decoder. A clocked driver feeds
// write and render beats from a backlog, a shadow copy of both screen pages
// predicts the eight pixels of each render, and a clocked monitor checks
// every pixel beat in order. The page select is changed between phases
// while the block is idle.
// ----------------------------------------------------------------------------
module tb_spectrum_screen_pixel_decoder_unit;

   localparam int PAGES      = sspd_pkg::DEFAULT_NUM_PAGES;
   localparam int SETTLE     = 6;
   localparam int TAIL       = 16;
   localparam int STUCK_MAX  = 2000;
   localparam int IDLE_PCT   = 7;

   // one request beat as queued for the driver
   typedef struct {
      sspd_pkg::op_type              op;
      logic                          page;
      logic [sspd_pkg::ADDR_W-1:0]   addr;
      logic [sspd_pkg::DATA_W-1:0]   data;
      logic [sspd_pkg::COL_W-1:0]    col;
      logic [sspd_pkg::LINE_W-1:0]   line;
      bit                            hold;
   } screen_beat_type;

   // one pixel beat
   typedef struct packed {
      logic [7:0]                    x;
      logic [sspd_pkg::LINE_W-1:0]   y;
      logic [sspd_pkg::COLOR_W-1:0]  color;
      logic                          last;
   } pixel_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_write_enable = 1'b0;
   logic                          csr_write_data = 1'b0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_operation = 1'b0;
   logic                          req_write_page = 1'b0;
   logic [sspd_pkg::ADDR_W-1:0]   req_write_address = '0;
   logic [sspd_pkg::DATA_W-1:0]   req_write_data = '0;
   logic [sspd_pkg::COL_W-1:0]    req_cell_column = '0;
   logic [sspd_pkg::LINE_W-1:0]   req_screen_line = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [7:0]                    rsp_pixel_x;
   logic [sspd_pkg::LINE_W-1:0]   rsp_pixel_y;
   logic [sspd_pkg::COLOR_W-1:0]  rsp_pixel_color;
   logic                          rsp_last_pixel;

   screen_beat_type  req_backlog[$];
   pixel_type        expected_pixels[$];
   screen_beat_type  live_beat;
   pixel_type        want;
   logic [7:0]       shadow_ram [0:PAGES-1][0:sspd_pkg::PAGE_BYTES-1];
   bit               gen_written [0:PAGES-1][0:sspd_pkg::PAGE_BYTES-1];
   logic             active_page = 1'b0;
   bit               calm = 1'b0;
   bit               hold_next = 1'b0;
   int               queued_items = 0;
   int               mismatch_count = 0;
   int               stuck_cycles = 0;

   spectrum_screen_pixel_decoder_unit #(.NUM_PAGES(PAGES)) dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_write_page    (req_write_page),
      .req_write_address (req_write_address),
      .req_write_data    (req_write_data),
      .req_cell_column   (req_cell_column),
      .req_screen_line   (req_screen_line),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_pixel_x       (rsp_pixel_x),
      .rsp_pixel_y       (rsp_pixel_y),
      .rsp_pixel_color   (rsp_pixel_color),
      .rsp_last_pixel    (rsp_last_pixel)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // interleaved bitmap offset of one cell line
   function automatic logic [sspd_pkg::ADDR_W-1:0] bitmap_offset(
         input logic [sspd_pkg::LINE_W-1:0] line,
         input logic [sspd_pkg::COL_W-1:0] col);
      return {line[7:6], line[2:0], line[5:3], col};
   endfunction

   // attribute offset of the cell holding this line
   function automatic logic [sspd_pkg::ADDR_W-1:0] attr_offset(
         input logic [sspd_pkg::LINE_W-1:0] line,
         input logic [sspd_pkg::COL_W-1:0] col);
      return sspd_pkg::ADDR_W'(sspd_pkg::ATTR_BASE + {line[7:3], col});
   endfunction

   // byte-swapped rgb565 colors, upper eight are bright
   function automatic logic [sspd_pkg::COLOR_W-1:0] palette_entry(input logic [3:0] idx);
      logic [sspd_pkg::COLOR_W-1:0] c;
      case (idx)
         4'd0:    c = 16'h0000;
         4'd1:    c = 16'h1B00;
         4'd2:    c = 16'h00B8;
         4'd3:    c = 16'h17B8;
         4'd4:    c = 16'hE005;
         4'd5:    c = 16'hF705;
         4'd6:    c = 16'hE0BD;
         4'd7:    c = 16'h18C6;
         4'd8:    c = 16'h0000;
         4'd9:    c = 16'h1F00;
         4'd10:   c = 16'h00F8;
         4'd11:   c = 16'h1FF8;
         4'd12:   c = 16'hE007;
         4'd13:   c = 16'hFF07;
         4'd14:   c = 16'hE0FF;
         default: c = 16'hFFFF;
      endcase
      return c;
   endfunction

   // update the shadow pages or work out the eight pixels of a render
   task automatic decode_beat(input screen_beat_type b);
      logic [7:0]                    bits;
      logic [7:0]                    attr;
      logic [3:0]                    ink_i;
      logic [3:0]                    paper_i;
      logic [sspd_pkg::COLOR_W-1:0]  ink;
      logic [sspd_pkg::COLOR_W-1:0]  paper;
      int                            pg;
      int                            i;
      pixel_type                     p;
      if (b.op == sspd_pkg::OP_WRITE) begin
         if (int'(b.page) < PAGES && int'(b.addr) < sspd_pkg::PAGE_BYTES)
            shadow_ram[b.page][b.addr] = b.data;
      end else begin
         bits  = 8'h00;
         ink   = palette_entry(4'd0);
         paper = ink;
         if (int'(b.line) < sspd_pkg::VISIBLE_LINES) begin
            pg      = (int'(active_page) < PAGES) ? int'(active_page) : 0;
            attr    = shadow_ram[pg][attr_offset(b.line, b.col)];
            bits    = shadow_ram[pg][bitmap_offset(b.line, b.col)];
            // flash bit is ignored, bright picks the upper palette half
            ink_i   = {attr[sspd_pkg::ATTR_BRIGHT_BIT], attr[2:0]};
            paper_i = {attr[sspd_pkg::ATTR_BRIGHT_BIT], attr[5:3]};
            ink     = palette_entry(ink_i);
            paper   = palette_entry(paper_i);
         end
         for (i = 0; i < 8; i++) begin
            p.x     = {b.col, 3'(i)};
            p.y     = b.line;
            p.color = bits[7 - i] ? ink : paper;
            p.last  = (i == 7);
            expected_pixels.push_back(p);
         end
      end
   endtask

   // stimulus helpers; don't-care fields are randomized
   task automatic queue_write(input logic page, input logic [sspd_pkg::ADDR_W-1:0] addr,
                              input logic [sspd_pkg::DATA_W-1:0] data);
      screen_beat_type b;
      b.op   = sspd_pkg::OP_WRITE;
      b.page = page;
      b.addr = addr;
      b.data = data;
      b.col  = sspd_pkg::COL_W'($urandom_range(31));
      b.line = sspd_pkg::LINE_W'($urandom_range(255));
      b.hold = hold_next;
      hold_next = 1'b0;
      req_backlog.push_back(b);
      queued_items++;
      if (int'(addr) < sspd_pkg::PAGE_BYTES) begin
         gen_written[page][addr] = 1'b1;
      end
   endtask

   task automatic queue_render(input logic [sspd_pkg::COL_W-1:0] col,
                               input logic [sspd_pkg::LINE_W-1:0] line);
      screen_beat_type b;
      b.op   = sspd_pkg::OP_RENDER;
      b.page = 1'($urandom_range(1));
      b.addr = sspd_pkg::ADDR_W'($urandom_range(8191));
      b.data = sspd_pkg::DATA_W'($urandom_range(255));
      b.col  = col;
      b.line = line;
      b.hold = hold_next;
      hold_next = 1'b0;
      req_backlog.push_back(b);
      queued_items++;
   endtask

   // make sure a cell line of the active page holds known bytes
   task automatic prepare_cell(input logic [sspd_pkg::LINE_W-1:0] line,
                               input logic [sspd_pkg::COL_W-1:0] col,
                               input bit fresh);
      logic [sspd_pkg::ADDR_W-1:0] bm;
      logic [sspd_pkg::ADDR_W-1:0] at;
      bm = bitmap_offset(line, col);
      at = attr_offset(line, col);
      if (fresh || !gen_written[active_page][bm])
         queue_write(active_page, bm, sspd_pkg::DATA_W'($urandom_range(255)));
      if (fresh || !gen_written[active_page][at])
         queue_write(active_page, at, sspd_pkg::DATA_W'($urandom_range(255)));
   endtask

   // mostly well-formed write-then-render sequences, some noise
   task automatic random_phase(input int target);
      int                            start;
      int                            r;
      logic [sspd_pkg::LINE_W-1:0]   line;
      logic [sspd_pkg::COL_W-1:0]    col;
      start = queued_items;
      while (queued_items - start < target) begin
         r    = $urandom_range(99);
         line = sspd_pkg::LINE_W'($urandom_range(sspd_pkg::VISIBLE_LINES - 1));
         col  = sspd_pkg::COL_W'($urandom_range(31));
         if (r < 35) begin
            prepare_cell(line, col, 1'b1);
            queue_render(col, line);
         end else if (r < 62) begin
            prepare_cell(line, col, 1'b0);
            queue_render(col, line);
         end else if (r < 80) begin
            queue_write(1'($urandom_range(1)),
                        sspd_pkg::ADDR_W'($urandom_range(sspd_pkg::PAGE_BYTES - 1)),
                        sspd_pkg::DATA_W'($urandom_range(255)));
         end else if (r < 90) begin
            queue_render(col,
                         sspd_pkg::LINE_W'($urandom_range(255, sspd_pkg::VISIBLE_LINES)));
         end else begin
            // past the end of the page, dropped by the block
            queue_write(1'($urandom_range(1)),
                        sspd_pkg::ADDR_W'($urandom_range(8191, sspd_pkg::PAGE_BYTES)),
                        sspd_pkg::DATA_W'($urandom_range(255)));
         end
      end
   endtask

   // wait until every queued beat is in and every pixel is out
   task automatic settle();
      while (req_backlog.size() != 0 || req_valid || expected_pixels.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_video_page(input logic v);
      csr_write_enable <= 1'b1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_page = v;
      @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid)
            decode_beat(live_beat);
         if (req_backlog.size() != 0 &&
             !(req_backlog[0].hold && expected_pixels.size() != 0) &&
             (calm || $urandom_range(99) >= IDLE_PCT)) begin
            live_beat = req_backlog.pop_front();
            req_valid         <= 1'b1;
            req_operation     <= live_beat.op;
            req_write_page    <= live_beat.page;
            req_write_address <= live_beat.addr;
            req_write_data    <= live_beat.data;
            req_cell_column   <= live_beat.col;
            req_screen_line   <= live_beat.line;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // pixel monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_pixels.size() == 0) begin
               $error("unexpected pixel beat x=%0d y=%0d", rsp_pixel_x, rsp_pixel_y);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_x !== want.x) begin
                  $error("pixel_x: expected %0d, got %0d", want.x, rsp_pixel_x);
                  mismatch_count++;
               end
               if (rsp_pixel_y !== want.y) begin
                  $error("pixel_y: expected %0d, got %0d", want.y, rsp_pixel_y);
                  mismatch_count++;
               end
               if (rsp_pixel_color !== want.color) begin
                  $error("pixel_color: expected %h, got %h", want.color, rsp_pixel_color);
                  mismatch_count++;
               end
               if (rsp_last_pixel !== want.last) begin
                  $error("last_pixel: expected %0d, got %0d", want.last, rsp_last_pixel);
                  mismatch_count++;
               end
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_MAX) begin
         $display("Mismatches found");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // test sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_video_page(1'b0);

      // corners of the screen and two inner cells, bright and flash attributes
      queue_write(1'b0, bitmap_offset(8'd0, 5'd0), 8'hFF);
      queue_write(1'b0, attr_offset(8'd0, 5'd0), 8'h47);
      queue_render(5'd0, 8'd0);
      queue_write(1'b0, bitmap_offset(8'd191, 5'd31), 8'h81);
      queue_write(1'b0, attr_offset(8'd191, 5'd31), 8'hBF);
      queue_render(5'd31, 8'd191);
      queue_write(1'b0, bitmap_offset(8'd100, 5'd17), 8'h5A);
      queue_write(1'b0, attr_offset(8'd100, 5'd17), 8'hF8);
      queue_render(5'd17, 8'd100);
      queue_write(1'b0, bitmap_offset(8'd63, 5'd8), 8'h00);
      queue_write(1'b0, attr_offset(8'd63, 5'd8), 8'h00);
      queue_render(5'd8, 8'd63);
      // writes past the page end are dropped, the last byte of page 1 is kept
      queue_write(1'b0, 13'd8191, 8'hFF);
      queue_write(1'b0, 13'd6912, 8'h00);
      queue_write(1'b1, 13'd6911, 8'h3C);
      // lines below the visible area
      queue_render(5'd0, 8'd192);
      queue_render(5'd31, 8'd255);
      // content for the second page
      queue_write(1'b1, bitmap_offset(8'd0, 5'd0), 8'h0F);
      queue_write(1'b1, attr_offset(8'd0, 5'd0), 8'h1A);
      random_phase(75);
      settle();

      // second page, no idling on either side
      set_video_page(1'b1);
      calm = 1'b1;
      queue_render(5'd0, 8'd0);
      prepare_cell(8'd191, 5'd31, 1'b0);
      queue_render(5'd31, 8'd191);
      random_phase(90);
      settle();
      calm = 1'b0;

      // back to the first page, sender drains once midway
      set_video_page(1'b0);
      random_phase(40);
      hold_next = 1'b1;
      random_phase(40);
      settle();

      repeat (TAIL) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         $error("%0d expected pixel beats never arrived", expected_pixels.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
